// File: rtl/core/alf_pkg.sv
`default_nettype none
package alf_pkg;

   localparam int COUNT_W   = 16;
   localparam int LUX_W     = 16;
   localparam int FLICKER_W = 7;
   localparam int CYC_W     = 9;
   localparam int GAIN_W    = 2;
   localparam int COEF_W    = 16;
   localparam int K_W       = 25;
   localparam int REG_IDX_W = 3;
   localparam int PADDR_W   = 5;
   localparam int PDATA_W   = 32;

   localparam logic [REG_IDX_W-1:0] REG_COEF_B    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF_C    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COEF_D    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_GDF       = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_INT_CYC   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_SEL  = 3'd5;

   localparam logic [COEF_W-1:0] COEF_B_RESET  = 16'd8192;
   localparam logic [COEF_W-1:0] COEF_C_RESET  = 16'd4096;
   localparam logic [COEF_W-1:0] COEF_D_RESET  = 16'd4096;
   localparam logic [COEF_W-1:0] GDF_RESET     = 16'd6400;
   localparam logic [CYC_W-1:0]  INT_CYC_RESET = 9'd1;
   localparam logic [GAIN_W-1:0] GAIN_RESET    = 2'd0;

   localparam logic [CYC_W-1:0]     CYC_MIN      = 9'd1;
   localparam logic [CYC_W-1:0]     CYC_MAX      = 9'd256;
   localparam logic [COEF_W-1:0]    PERIOD_Q8    = 16'd699;
   localparam logic [LUX_W-1:0]     LUX_SAT      = 16'hFFFF;
   localparam logic [FLICKER_W-1:0] FLICKER_MAX  = 7'd100;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_D,
      ST_MUL_K1,
      ST_MUL_K2,
      ST_MUL_G,
      ST_LUX_CHK,
      ST_LUX_DIV,
      ST_UPDATE,
      ST_FLK_MUL,
      ST_FLK_CHK,
      ST_FLK_DIV,
      ST_DONE
   } state_type;

   function automatic logic [COEF_W-1:0] gain_value(input logic [GAIN_W-1:0] sel);
      logic [COEF_W-1:0] g;
      case (sel)
         2'd0:    g = 16'd1;
         2'd1:    g = 16'd8;
         2'd2:    g = 16'd16;
         2'd3:    g = 16'd120;
         default: g = 16'd1;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/alf_req_if.sv
`default_nettype none
interface alf_req_if import alf_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] visible_count;
   logic [COUNT_W-1:0] infrared_count;

   modport source (output valid, output visible_count, output infrared_count, input ready);
   modport sink   (input valid, input visible_count, input infrared_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/alf_rsp_if.sv
`default_nettype none
interface alf_rsp_if import alf_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [LUX_W-1:0]     lux;
   logic [FLICKER_W-1:0] flicker_percent;
   logic                 window_done;

   modport source (output valid, output lux, output flicker_percent, output window_done,
                   input ready);
   modport sink   (input valid, input lux, input flicker_percent, input window_done,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/core/ambient_lux_and_flicker_core.sv
// Ambient light lux and flicker core.
// req carries one beat per sensor sample: visible_count (channel 0) and
// infrared_count (channel 1). rsp returns one beat per sample: lux, and on
// the sample that closes a window of SAMPLES beats, window_done with the
// flicker percentage of that window.
// A small sequencer drives one shared 32x16 multiplier and one
// compare/subtract divider step, so req.ready is high only while the core
// is idle. A sample runs through 6 multiply steps, one range check, 16 divider
// steps (none when lux saturates), one window update and one handoff;
// a sample closing a window adds a flicker multiply, check and division.
// req.ready rises again in the cycle after the result is handed off, so a
// new req beat is not taken before the last sample is through.
// The result sits in an output register; a stalled rsp holds it while the
// next sample is computed, and the core waits only if that next result is
// ready before the old one is taken.
// Reset (synchronous, active high) restores the default configuration and
// clears the window. Registers are written over the APB-style port; the user
// must write them only while the core is idle, which the core does not enforce.
`default_nettype none
module ambient_lux_and_flicker_core import alf_pkg::*; #(
   parameter int SAMPLES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   alf_req_if.sink                 req,
   alf_rsp_if.source               rsp,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   localparam int SUM_W = $clog2(SAMPLES * 65535 + 1);
   localparam int CNT_W = $clog2(SAMPLES);
   localparam int DVS_W = (K_W > SUM_W + 1) ? K_W : SUM_W + 1;
   localparam int DIV_W = DVS_W + 1;
   localparam logic [COEF_W-1:0] FLK_SCALE = COEF_W'(100 * SAMPLES);
   localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(SAMPLES - 1);

   // configuration
   logic [COEF_W-1:0] coef_b_ff, coef_c_ff, coef_d_ff, gdf_ff;
   logic [CYC_W-1:0]  int_cyc_ff;
   logic [GAIN_W-1:0] gain_sel_ff;
   logic              cfg_write;
   logic [REG_IDX_W-1:0] cfg_idx;

   // sequencer and datapath
   state_type state_ff, state_in;
   logic [COUNT_W-1:0]   ch0_ff, ch0_in, ch1_ff, ch1_in;
   logic signed [32:0]   t1_ff, t1_in;
   logic [31:0]          p2_ff, p2_in;
   logic [31:0]          best_ff, best_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic [35:0]          num_ff, num_in;
   logic [DIV_W-1:0]     rem_ff, rem_in, dvsr_ff, dvsr_in;
   logic [15:0]          quo_ff, quo_in;
   logic [3:0]           step_ff, step_in;
   logic [LUX_W-1:0]     lux_ff, lux_in;
   logic [FLICKER_W-1:0] flk_ff, flk_in;
   logic                 done_ff, done_in;

   // window
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LUX_W-1:0] min_ff, min_in, max_ff, max_in;
   logic [SUM_W-1:0] sum_ff, sum_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LUX_W-1:0]     rsp_lux_ff, rsp_lux_in;
   logic [FLICKER_W-1:0] rsp_flk_ff, rsp_flk_in;
   logic                 rsp_done_ff, rsp_done_in;

   // shared units
   logic [31:0]        mul_a;
   logic [COEF_W-1:0]  mul_b;
   logic [47:0]        prod;
   logic [CYC_W-1:0]   cyc;
   logic signed [32:0] t2;
   logic signed [32:0] tmax;
   logic [DIV_W-1:0]   rem_sh;
   logic               qbit;
   logic [DIV_W-1:0]   rem_step;
   logic               rsp_free;
   logic               req_beat;

   assign cfg_write = psel & penable & pwrite;
   assign cfg_idx   = paddr[4:2];
   assign pready    = 1'b1;

   always_comb begin
      case (cfg_idx)
         REG_COEF_B:   prdata = PDATA_W'(coef_b_ff);
         REG_COEF_C:   prdata = PDATA_W'(coef_c_ff);
         REG_COEF_D:   prdata = PDATA_W'(coef_d_ff);
         REG_GDF:      prdata = PDATA_W'(gdf_ff);
         REG_INT_CYC:  prdata = PDATA_W'(int_cyc_ff);
         REG_GAIN_SEL: prdata = PDATA_W'(gain_sel_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b_ff   <= COEF_B_RESET;
         coef_c_ff   <= COEF_C_RESET;
         coef_d_ff   <= COEF_D_RESET;
         gdf_ff      <= GDF_RESET;
         int_cyc_ff  <= INT_CYC_RESET;
         gain_sel_ff <= GAIN_RESET;
      end else if (cfg_write) begin
         case (cfg_idx)
            REG_COEF_B:   coef_b_ff   <= pwdata[COEF_W-1:0];
            REG_COEF_C:   coef_c_ff   <= pwdata[COEF_W-1:0];
            REG_COEF_D:   coef_d_ff   <= pwdata[COEF_W-1:0];
            REG_GDF:      gdf_ff      <= pwdata[COEF_W-1:0];
            REG_INT_CYC:  int_cyc_ff  <= pwdata[CYC_W-1:0];
            REG_GAIN_SEL: gain_sel_ff <= pwdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (int_cyc_ff < CYC_MIN) begin
         cyc = CYC_MIN;
      end else if (int_cyc_ff > CYC_MAX) begin
         cyc = CYC_MAX;
      end else begin
         cyc = int_cyc_ff;
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_MUL_B: begin
            mul_a = 32'(ch1_ff);
            mul_b = coef_b_ff;
         end
         ST_MUL_C: begin
            mul_a = 32'(ch0_ff);
            mul_b = coef_c_ff;
         end
         ST_MUL_D: begin
            mul_a = 32'(ch1_ff);
            mul_b = coef_d_ff;
         end
         ST_MUL_K1: begin
            mul_a = 32'(cyc);
            mul_b = PERIOD_Q8;
         end
         ST_MUL_K2: begin
            mul_a = 32'(k_ff);
            mul_b = gain_value(gain_sel_ff);
         end
         ST_MUL_G: begin
            mul_a = best_ff;
            mul_b = gdf_ff;
         end
         ST_FLK_MUL: begin
            mul_a = 32'(max_ff - min_ff);
            mul_b = FLK_SCALE;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = 48'(mul_a) * 48'(mul_b);

   // shared restoring divider step
   assign rem_sh   = {rem_ff[DIV_W-2:0], quo_ff[15]};
   assign qbit     = (rem_sh >= dvsr_ff);
   assign rem_step = qbit ? rem_sh - dvsr_ff : rem_sh;

   assign t2   = $signed({1'b0, p2_ff}) - $signed({1'b0, prod[31:0]});
   assign tmax = (t1_ff > t2) ? t1_ff : t2;

   assign req_beat = req.valid & req.ready;
   assign rsp_free = ~rsp_valid_ff | rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_beat) state_in = ST_MUL_B;
         ST_MUL_B:   state_in = ST_MUL_C;
         ST_MUL_C:   state_in = ST_MUL_D;
         ST_MUL_D:   state_in = ST_MUL_K1;
         ST_MUL_K1:  state_in = ST_MUL_K2;
         ST_MUL_K2:  state_in = ST_MUL_G;
         ST_MUL_G:   state_in = ST_LUX_CHK;
         ST_LUX_CHK: begin
            if (K_W'(num_ff[35:16]) >= k_ff) begin
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_LUX_DIV;
            end
         end
         ST_LUX_DIV: if (step_ff == '0) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FLK_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FLK_MUL: state_in = ST_FLK_CHK;
         ST_FLK_CHK: begin
            if (sum_ff == '0 || DIV_W'(num_ff[31:7]) >= dvsr_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FLK_DIV;
            end
         end
         ST_FLK_DIV: if (step_ff == '0) state_in = ST_DONE;
         ST_DONE:    if (rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready           = (state_ff == ST_IDLE);
      rsp.valid           = rsp_valid_ff;
      rsp.lux             = rsp_lux_ff;
      rsp.flicker_percent = rsp_flk_ff;
      rsp.window_done     = rsp_done_ff;
   end

   // datapath
   always_comb begin
      ch0_in       = ch0_ff;
      ch1_in       = ch1_ff;
      t1_in        = t1_ff;
      p2_in        = p2_ff;
      best_in      = best_ff;
      k_in         = k_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      dvsr_in      = dvsr_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      lux_in       = lux_ff;
      flk_in       = flk_ff;
      done_in      = done_ff;
      cnt_in       = cnt_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      rsp_lux_in   = rsp_lux_ff;
      rsp_flk_in   = rsp_flk_ff;
      rsp_done_in  = rsp_done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               ch0_in = req.visible_count;
               ch1_in = req.infrared_count;
            end
         end
         ST_MUL_B: t1_in = $signed({5'b0, ch0_ff, 12'b0}) - $signed({1'b0, prod[31:0]});
         ST_MUL_C: p2_in = prod[31:0];
         ST_MUL_D: best_in = tmax[32] ? 32'd0 : tmax[31:0];
         ST_MUL_K1: k_in = prod[K_W-1:0];
         ST_MUL_K2: k_in = prod[K_W-1:0];
         ST_MUL_G: num_in = prod[47:12];
         ST_LUX_CHK: begin
            lux_in  = LUX_SAT;
            rem_in  = DIV_W'(num_ff[35:16]);
            dvsr_in = DIV_W'(k_ff);
            quo_in  = num_ff[15:0];
            step_in = 4'd15;
         end
         ST_LUX_DIV: begin
            rem_in  = rem_step;
            quo_in  = {quo_ff[14:0], qbit};
            lux_in  = {quo_ff[14:0], qbit};
            step_in = step_ff - 4'd1;
         end
         ST_UPDATE: begin
            if (lux_ff < min_ff) min_in = lux_ff;
            if (lux_ff > max_ff) max_in = lux_ff;
            sum_in = sum_ff + SUM_W'(lux_ff);
            flk_in = '0;
            if (cnt_ff == CNT_LAST) begin
               done_in = 1'b1;
            end else begin
               done_in = 1'b0;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         ST_FLK_MUL: begin
            num_in  = 36'(prod[31:0]);
            dvsr_in = DIV_W'({sum_ff, 1'b0});
         end
         ST_FLK_CHK: begin
            if (sum_ff == '0) begin
               flk_in = '0;
            end else if (DIV_W'(num_ff[31:7]) >= dvsr_ff) begin
               flk_in = FLICKER_MAX;
            end else begin
               rem_in  = DIV_W'(num_ff[31:7]);
               quo_in  = {num_ff[6:0], 9'b0};
               step_in = 4'd6;
            end
         end
         ST_FLK_DIV: begin
            rem_in  = rem_step;
            quo_in  = {quo_ff[14:0], qbit};
            step_in = step_ff - 4'd1;
            if ({quo_ff[5:0], qbit} > FLICKER_MAX) begin
               flk_in = FLICKER_MAX;
            end else begin
               flk_in = {quo_ff[5:0], qbit};
            end
         end
         ST_DONE: begin
            if (done_ff) begin
               cnt_in = '0;
               min_in = LUX_SAT;
               max_in = '0;
               sum_in = '0;
            end
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_lux_in   = lux_ff;
               rsp_flk_in   = flk_ff;
               rsp_done_in  = done_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         min_ff       <= LUX_SAT;
         max_ff       <= '0;
         sum_ff       <= '0;
         step_ff      <= '0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         step_ff      <= step_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ch0_ff      <= ch0_in;
      ch1_ff      <= ch1_in;
      t1_ff       <= t1_in;
      p2_ff       <= p2_in;
      best_ff     <= best_in;
      k_ff        <= k_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      dvsr_ff     <= dvsr_in;
      quo_ff      <= quo_in;
      lux_ff      <= lux_in;
      flk_ff      <= flk_in;
      rsp_lux_ff  <= rsp_lux_in;
      rsp_flk_ff  <= rsp_flk_in;
      rsp_done_ff <= rsp_done_in;
   end

endmodule
`default_nettype wire
